// File: sv/tst_pkg.sv
// Shared types and codes for the thread slot table.
// No dependencies; imported by thread_slot_table.
package tst_pkg;

  typedef enum logic [1:0] {
    FUNC_START       = 2'd0,
    FUNC_STOP_SCRIPT = 2'd1,
    FUNC_QUERY       = 2'd2,
    FUNC_STOP_SLOT   = 2'd3
  } func_t;

  localparam logic CFG_ACTIVE_SLOTS   = 1'b0;
  localparam logic CFG_RECURSIVE_MASK = 1'b1;

  localparam int unsigned ACTIVE_W = 5;
  localparam int unsigned MASK_W   = 8;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
  localparam logic [MASK_W-1:0]   MASK_RESET   = 8'd1;
  localparam logic [4:0]          STOP_CNT_MAX = 5'd31;

  typedef struct packed {
    logic [31:0] start_cycle;
    logic [15:0] start_offset;
    logic [7:0]  thread_flags;
    logic [15:0] script_id;
  } slot_entry_t;

endpackage

// File: sv/thread_slot_table.sv
// Thread slot table: per-slot script info in a synchronous memory, running marks in flops.
// Start, stop script, query: scan active slots one per cycle, then load the result in the
// finish state. Stop slot: go straight from accept to the finish state and load the result.
// Next word accepted the cycle after the result loads; a held output word stalls the load.
// Synchronous reset clears all running marks, drops any output word, and restores the
// register defaults (16 active slots, recursive mask 1). Depends on tst_pkg.
module thread_slot_table
  import tst_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // script_id[15:0], slot_index[19:16], start_offset[35:20],
  // thread_flags[43:36], current_cycle[75:44], zero fill
  input  logic [79:0] s_tdata,
  // func[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[0], granted_slot[4:1], is_running[5], stopped_count[10:6], zero fill
  output logic [15:0] m_tdata
);

  localparam int unsigned AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned LW = (CW > ACTIVE_W) ? CW : ACTIVE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                state;
  logic [ACTIVE_W-1:0]   active_slots;
  logic [MASK_W-1:0]     recursive_mask;
  logic [NUM_SLOTS-1:0]  marks;

  func_t                 cur_func;
  slot_entry_t           cur_entry;
  logic                  stop_mode;
  logic [LW-1:0]         iss;
  logic                  pend;
  logic [AW-1:0]         pend_idx;
  logic                  free_found;
  logic [AW-1:0]         free_idx;
  logic                  any_hit;
  logic [4:0]            stopped;

  slot_entry_t           mem [NUM_SLOTS];
  slot_entry_t           rd_entry;

  logic [LW-1:0]         live;
  logic                  issue;
  logic                  hit;
  logic                  keep;
  logic                  out_free;
  logic                  mem_we;
  func_t                 in_func;
  logic [3:0]            in_slot;
  logic [AW-1:0]         in_sel;
  logic                  in_sel_ok;

  always_comb begin
    live      = (LW'(active_slots) > LW'(NUM_SLOTS)) ? LW'(NUM_SLOTS) : LW'(active_slots);
    issue     = (state == ST_SCAN) && (iss < live);
    hit       = pend && marks[pend_idx] && (rd_entry.script_id == cur_entry.script_id);
    keep      = marks[pend_idx] && !(stop_mode && hit);
    out_free  = !m_tvalid || m_tready;
    mem_we    = (state == ST_FINISH) && (cur_func == FUNC_START) && free_found;
    in_func   = func_t'(s_tuser);
    in_slot   = s_tdata[19:16];
    in_sel    = AW'(in_slot);
    in_sel_ok = 8'(in_slot) < 8'(NUM_SLOTS);
    s_tready  = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[free_idx] <= cur_entry;
    end
    if (issue) begin
      rd_entry <= mem[iss[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      active_slots   <= ACTIVE_RESET;
      recursive_mask <= MASK_RESET;
      marks          <= '0;
      pend           <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ACTIVE_SLOTS:   active_slots   <= cfg_wdata[ACTIVE_W-1:0];
          CFG_RECURSIVE_MASK: recursive_mask <= cfg_wdata[MASK_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur_func               <= in_func;
            cur_entry.script_id    <= s_tdata[15:0];
            cur_entry.start_offset <= s_tdata[35:20];
            cur_entry.thread_flags <= s_tdata[43:36];
            cur_entry.start_cycle  <= s_tdata[75:44];
            stop_mode  <= (in_func == FUNC_STOP_SCRIPT) ||
                          ((in_func == FUNC_START) &&
                           ((s_tdata[43:36] & recursive_mask) == '0));
            iss        <= '0;
            pend       <= 1'b0;
            free_found <= 1'b0;
            free_idx   <= '0;
            any_hit    <= 1'b0;
            if (in_func == FUNC_STOP_SLOT) begin
              if (in_sel_ok && marks[in_sel]) begin
                marks[in_sel] <= 1'b0;
              end
              stopped <= {4'd0, in_sel_ok && marks[in_sel]};
              state   <= ST_FINISH;
            end else begin
              stopped <= '0;
              state   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (pend) begin
            if (stop_mode && hit) begin
              marks[pend_idx] <= 1'b0;
              if (stopped != STOP_CNT_MAX) begin
                stopped <= stopped + 5'd1;
              end
            end
            if (hit) begin
              any_hit <= 1'b1;
            end
            if (!free_found && !keep) begin
              free_found <= 1'b1;
              free_idx   <= pend_idx;
            end
          end
          pend     <= issue;
          pend_idx <= iss[AW-1:0];
          if (issue) begin
            iss <= iss + LW'(1);
          end
          if (!issue && !pend) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            if (mem_we) begin
              marks[free_idx] <= 1'b1;
            end
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, stopped, (cur_func == FUNC_QUERY) && any_hit,
                         mem_we ? 4'(free_idx) : 4'd0,
                         (cur_func == FUNC_START) && !free_found};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sv/tst_checker.sv
// Port-level checks for thread_slot_table, attached by bind.
// Depends only on the top-level port list.
module tst_checker #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while one is in work");

  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> (m_tdata[4:1] == 4'd0) && !m_tdata[5])
    else $error("failed start carries a slot or a query answer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:11] == 5'd0) && (32'(m_tdata[10:6]) <= NUM_SLOTS))
    else $error("stopped count out of range");

endmodule

bind thread_slot_table tst_checker #(.NUM_SLOTS(NUM_SLOTS)) u_tst_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
